>>> rtl/core/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the 24-bit BMP stream decoder files.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Header layout (byte positions from the start of the file)
  localparam int unsigned  HDR_LEN  = 54;
  localparam logic [5:0]   POS_LAST = 6'd53;
  localparam logic [5:0]   POS_SIG0 = 6'd0;
  localparam logic [5:0]   POS_SIG1 = 6'd1;
  localparam logic [5:0]   POS_OFS  = 6'd10;
  localparam logic [5:0]   POS_WID  = 6'd18;
  localparam logic [5:0]   POS_HGT  = 6'd22;
  localparam logic [5:0]   POS_BPP  = 6'd28;
  localparam logic [5:0]   POS_CMP  = 6'd30;

  // Signature characters and supported depth
  localparam logic [7:0]   CHR_B    = 8'h42;
  localparam logic [7:0]   CHR_M    = 8'h4D;
  localparam logic [15:0]  BPP_24   = 16'd24;

  // Result kinds
  localparam logic         KIND_PIXEL = 1'b0;
  localparam logic         KIND_ERROR = 1'b1;

  // Error codes
  localparam logic [1:0]   ERR_NONE      = 2'd0;
  localparam logic [1:0]   ERR_SIGNATURE = 2'd1;
  localparam logic [1:0]   ERR_FORMAT    = 2'd2;
  localparam logic [1:0]   ERR_SIZE      = 2'd3;

  // Header status handed from the header unit to the stream control
  typedef struct packed {
    logic       fail;    // header rejected at this byte
    logic [1:0] code;    // error code when fail is set
    logic       done;    // header accepted at its last byte
    logic       empty;   // zero height, nothing to decode
    logic       direct;  // pixel data starts straight after the header
  } hdr_stat_t;

endpackage

>>> rtl/core/bmpd_in_if.sv
// ----------------------------------------------------------------------------
// bmpd_in_if
// Byte request channel into the BMP decoder: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_flag;

  modport source (output valid, output file_byte, output start_flag, input ready);
  modport sink   (input valid, input file_byte, input start_flag, output ready);
endinterface

>>> rtl/core/bmpd_out_if.sv
// ----------------------------------------------------------------------------
// bmpd_out_if
// Result request channel out of the BMP decoder: pixels and error reports.
// ----------------------------------------------------------------------------
interface bmpd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  error_code;
  logic [11:0] column;
  logic [11:0] row;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        final_pixel;

  modport source (output valid, output result_kind, output error_code, output column,
                  output row, output red, output green, output blue, output final_pixel,
                  input ready);
  modport sink   (input valid, input result_kind, input error_code, input column,
                  input row, input red, input green, input blue, input final_pixel,
                  output ready);
endinterface

>>> rtl/core/bmpd_header.sv
// ----------------------------------------------------------------------------
// bmpd_header
// Captures little-endian header fields, checks the signature on bytes 0 and 1
// and the rest at the last header byte; holds the decoded geometry for the pixel stage.
// ----------------------------------------------------------------------------
module bmpd_header #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic               clk,
  input  logic               en_i,       // header byte accepted this cycle
  input  logic [5:0]         pos_i,      // its position in the file
  input  logic [7:0]         byte_i,
  output bmpd_pkg::hdr_stat_t stat_o,
  output logic [WW-1:0]      width_o,
  output logic [HW-1:0]      hmag_o,
  output logic               top_down_o,
  output logic [31:0]        offset_o
);
  import bmpd_pkg::*;

  logic [31:0]   offset_r;
  logic [31:0]   width_r;
  logic [31:0]   height_r;
  logic [15:0]   depth_r;
  logic          comp_nz_r;
  logic [HW-1:0] hmag_r;
  logic          top_down_r;

  logic [1:0]  lane_ofs, lane_wid, lane_hgt;
  logic        lane_bpp;
  logic [31:0] hmag32;
  logic        sig_bad, at_end, fmt_bad, size_bad;

  // byte lane within each field
  assign lane_ofs = 2'(pos_i - POS_OFS);
  assign lane_wid = 2'(pos_i - POS_WID);
  assign lane_hgt = 2'(pos_i - POS_HGT);
  assign lane_bpp = 1'(pos_i - POS_BPP);

  // field capture; every field is fully rewritten before it is checked
  always_ff @(posedge clk) begin
    if (en_i) begin
      if (pos_i >= POS_OFS && pos_i < POS_OFS + 6'd4) begin
        offset_r[{lane_ofs, 3'b000} +: 8] <= byte_i;
      end
      if (pos_i >= POS_WID && pos_i < POS_WID + 6'd4) begin
        width_r[{lane_wid, 3'b000} +: 8] <= byte_i;
      end
      if (pos_i >= POS_HGT && pos_i < POS_HGT + 6'd4) begin
        height_r[{lane_hgt, 3'b000} +: 8] <= byte_i;
      end
      if (pos_i >= POS_BPP && pos_i < POS_BPP + 6'd2) begin
        depth_r[{lane_bpp, 3'b000} +: 8] <= byte_i;
      end
      if (pos_i == POS_CMP) begin
        comp_nz_r <= (byte_i != 8'd0);
      end else if (pos_i > POS_CMP && pos_i < POS_CMP + 6'd4) begin
        comp_nz_r <= comp_nz_r | (byte_i != 8'd0);
      end
    end
  end

  // checks
  assign hmag32   = height_r[31] ? (32'd0 - height_r) : height_r;
  assign sig_bad  = (pos_i == POS_SIG0 && byte_i != CHR_B) ||
                    (pos_i == POS_SIG1 && byte_i != CHR_M);
  assign at_end   = (pos_i == POS_LAST);
  assign fmt_bad  = (depth_r != BPP_24) || comp_nz_r;
  assign size_bad = (width_r == 32'd0) || width_r[31] ||
                    (width_r > 32'(MAX_WIDTH)) || (hmag32 > 32'(MAX_HEIGHT)) ||
                    (offset_r < 32'(HDR_LEN));

  always_comb begin
    stat_o.fail   = en_i && (sig_bad || (at_end && (fmt_bad || size_bad)));
    stat_o.code   = sig_bad ? ERR_SIGNATURE : (fmt_bad ? ERR_FORMAT : ERR_SIZE);
    stat_o.done   = en_i && !sig_bad && at_end && !fmt_bad && !size_bad;
    stat_o.empty  = (hmag32 == 32'd0);
    stat_o.direct = (offset_r == 32'(HDR_LEN));
  end

  // geometry latched once the header has passed
  always_ff @(posedge clk) begin
    if (stat_o.done) begin
      hmag_r     <= hmag32[HW-1:0];
      top_down_r <= height_r[31];
    end
  end

  assign width_o    = width_r[WW-1:0];
  assign hmag_o     = hmag_r;
  assign top_down_o = top_down_r;
  assign offset_o   = offset_r;

endmodule

>>> rtl/core/bmp24_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_core
// Uncompressed 24-bit BMP decoder: a file byte stream in, one request per
// pixel (or one error report per file) out.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock while in_ch.ready is high and
// registers each pixel as its red byte is accepted; the result register is
// the only storage between the channels, so in_ch.ready falls only while a
// result waits for out_ch.ready. Raise start_flag on the first byte of every
// file; after reset the first byte is taken as byte 0 anyway. Header bytes
// 0..53 are parsed, the stream is skipped to the data offset, then BGR
// triplets are decoded with the row padding dropped. A bad signature, a depth
// other than 24 or non-zero compression, a width that is zero, negative or
// beyond MAX_WIDTH, a height beyond MAX_HEIGHT (or offset below 54) yields a
// single error report; afterwards, and after the last pixel, bytes are consumed
// and ignored until the next start_flag. Negative heights give top-down files
// with mirrored row numbers. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic  clk,
  input  logic  rst_n,
  bmpd_in_if.sink    in_ch,
  bmpd_out_if.source out_ch
);
  import bmpd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  // channel phases within a triplet
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  logic [2:0]    phase_r, phase_cur, phase_nxt;
  logic [31:0]   pos_r, pos_cur, pos_inc;
  logic [1:0]    chan_r;
  logic [WW-1:0] col_r;
  logic [HW-1:0] row_r;
  logic [1:0]    pad_r;
  logic [7:0]    blue_r, green_r;

  logic          accept;
  hdr_stat_t     hstat;
  logic [WW-1:0] width;
  logic [HW-1:0] hmag;
  logic          top_down;
  logic [31:0]   offset;

  logic          last_col, last_pix;
  logic [31:0]   col32, y32;

  // result register
  logic          out_valid_r;
  logic          kind_r;
  logic [1:0]    code_r;
  logic [11:0]   col_out_r, row_out_r;
  logic [7:0]    red_r, green_out_r, blue_out_r;
  logic          final_r;
  logic          emit, emit_err;

  // handshake: a new byte whenever the result slot is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // start_flag restarts the parse at byte 0
  assign phase_cur = in_ch.start_flag ? PH_HEADER : phase_r;
  assign pos_cur   = in_ch.start_flag ? 32'd0 : pos_r;
  assign pos_inc   = pos_cur + 32'd1;

  bmpd_header #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_header (
    .clk        (clk),
    .en_i       (accept && phase_cur == PH_HEADER),
    .pos_i      (pos_cur[5:0]),
    .byte_i     (in_ch.file_byte),
    .stat_o     (hstat),
    .width_o    (width),
    .hmag_o     (hmag),
    .top_down_o (top_down),
    .offset_o   (offset)
  );

  // pixel coordinates
  assign last_col = (col_r + WW'(1)) == width;
  assign last_pix = last_col && ((row_r + HW'(1)) == hmag);
  assign col32    = 32'(col_r);
  assign y32      = top_down ? (32'(hmag) - 32'd1 - 32'(row_r)) : 32'(row_r);

  // phase sequencing and result decision
  always_comb begin
    phase_nxt = phase_cur;
    emit      = 1'b0;
    emit_err  = 1'b0;
    unique case (phase_cur)
      PH_HEADER: begin
        if (hstat.fail) begin
          emit      = 1'b1;
          emit_err  = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (hstat.done) begin
          if (hstat.empty) begin
            phase_nxt = PH_IDLE;
          end else if (hstat.direct) begin
            phase_nxt = PH_PIXEL;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (pos_inc >= offset) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PAD: begin
        if (pad_r <= 2'd1) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (chan_r == CH_RED) begin
          emit = 1'b1;
          if (last_pix) begin
            phase_nxt = PH_IDLE;
          end else if (last_col && width[1:0] != 2'd0) begin
            phase_nxt = PH_PAD;
          end
        end
      end
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      chan_r  <= CH_BLUE;
      col_r   <= '0;
      row_r   <= '0;
      pad_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= (pos_cur == 32'hFFFF_FFFF) ? pos_cur : pos_inc;
      if (in_ch.start_flag) begin
        chan_r <= CH_BLUE;
        col_r  <= '0;
        row_r  <= '0;
        pad_r  <= '0;
      end else if (phase_cur == PH_PAD) begin
        if (pad_r != 2'd0) begin
          pad_r <= pad_r - 2'd1;
        end
      end else if (phase_cur == PH_PIXEL) begin
        case (chan_r)
          CH_BLUE:  chan_r <= CH_GREEN;
          CH_GREEN: chan_r <= CH_RED;
          default: begin
            chan_r <= CH_BLUE;
            if (!last_pix) begin
              if (last_col) begin
                col_r <= '0;
                row_r <= row_r + HW'(1);
                // padding to a 4-byte row: (4 - 3w mod 4) mod 4 == w mod 4
                pad_r <= width[1:0];
              end else begin
                col_r <= col_r + WW'(1);
              end
            end
          end
        endcase
      end
    end
  end

  // held channel bytes
  always_ff @(posedge clk) begin
    if (accept && phase_cur == PH_PIXEL) begin
      if (chan_r == CH_BLUE) begin
        blue_r <= in_ch.file_byte;
      end
      if (chan_r == CH_GREEN) begin
        green_r <= in_ch.file_byte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (emit_err) begin
        kind_r      <= KIND_ERROR;
        code_r      <= hstat.code;
        col_out_r   <= '0;
        row_out_r   <= '0;
        red_r       <= '0;
        green_out_r <= '0;
        blue_out_r  <= '0;
        final_r     <= 1'b0;
      end else begin
        kind_r      <= KIND_PIXEL;
        code_r      <= ERR_NONE;
        col_out_r   <= col32[11:0];
        row_out_r   <= y32[11:0];
        red_r       <= in_ch.file_byte;
        green_out_r <= green_r;
        blue_out_r  <= blue_r;
        final_r     <= last_pix;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = kind_r;
  assign out_ch.error_code  = code_r;
  assign out_ch.column      = col_out_r;
  assign out_ch.row         = row_out_r;
  assign out_ch.red         = red_r;
  assign out_ch.green       = green_out_r;
  assign out_ch.blue        = blue_out_r;
  assign out_ch.final_pixel = final_r;

endmodule
